>>> rtl/core/sprb_pkg.sv
// ----------------------------------------------------------------------------
// sprb_pkg: shared types and constants for the prime root bucketer
// Field structs, config indexes and sizing constants.
// ----------------------------------------------------------------------------
package sprb_pkg;

	localparam int FLAG_BITS  = 18;
	localparam int MAX_BLOCKS = 64;
	localparam int SLOT_BITS  = 16;
	localparam int BLK_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int CFG_DATA_W = 42;
	localparam int CFG_IDX_W  = 2;

	// counter store: normal buckets in the low half, large in the high half
	localparam int FILL_DEPTH = 2 * MAX_BLOCKS;
	localparam int FILL_AW    = BLK_W + 1;

	localparam logic [CFG_IDX_W-1:0] CFG_CLASS_DIFF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MOD_PROD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SPAN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_CNT  = 2'd3;

	localparam logic [SLOT_BITS-1:0] SLOT_MAX = '1;

	typedef struct packed {
		logic        start_req;
		logic [31:0] prime;
		logic [31:0] inverse;
		logic [31:0] low_residue;
	} in_item_t;

	typedef struct packed {
		logic        hit_valid;
		logic        large_mode;
		logic [5:0]  bucket_index;
		logic [15:0] slot_index;
		logic [23:0] hit_offset;
		logic [31:0] prime_echo;
		logic        slot_overflow;
	} out_item_t;

	// front -> back: classified item with reduced hit
	typedef struct packed {
		logic             start_req;
		logic             switch_now;
		logic             hit_valid;
		logic [BLK_W-1:0] bucket;
		logic [23:0]      hit;
		logic [31:0]      prime;
	} job_t;

endpackage

>>> rtl/core/sieve_prime_root_bucketer.sv
// ----------------------------------------------------------------------------
// sieve_prime_root_bucketer: first-hit bucketer for sieving primes
// Computes each prime's first hit in the line and assigns a bucket slot.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_ready carry one request per prime: start flag, prime,
//    inverse and low residue. out_valid/out_ready return one result each.
//  - The front reduces (low + class_difference) mod prime, multiplies by
//    the inverse and reduces again, all through one shared 1-bit-per-cycle
//    remainder unit, and takes one request at a time.
//  - The back reads the bucket counter when it takes a job and writes it
//    back with the result in the next cycle.
//  - The back keeps the normal and large bucket counters (valid bits per
//    counter stand in for clearing) and holds the result in a register;
//    the front may start the next request while a result waits.
//  - A receiver stall holds the result; the back then stalls the front.
//  - Reset clears mode and counters and loads the register defaults.
//  - Config writes (cfg_we, cfg_idx, cfg_data) only while idle.
// ----------------------------------------------------------------------------
module sieve_prime_root_bucketer import sprb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [23:0] class_diff_q;
	logic [23:0] mod_prod_q;
	logic [41:0] block_span_q;
	logic [6:0]  block_cnt_q;
	logic        job_valid, job_ready;
	job_t        job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_diff_q <= '0;
			mod_prod_q   <= 24'd30;
			block_span_q <= 42'd7864320;
			block_cnt_q  <= 7'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_CLASS_DIFF: class_diff_q <= cfg_data[23:0];
				CFG_MOD_PROD:   mod_prod_q   <= cfg_data[23:0];
				CFG_BLOCK_SPAN: block_span_q <= cfg_data;
				CFG_BLOCK_CNT:  block_cnt_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	sprb_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .ready(in_ready),
		.req(in_data), .class_difference(class_diff_q),
		.modulus_product(mod_prod_q), .block_span(block_span_q),
		.block_count(block_cnt_q), .job_valid(job_valid),
		.job_ready(job_ready), .job(job)
	);

	sprb_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid),
		.job_ready(job_ready), .job(job), .out_valid(out_valid),
		.out_ready(out_ready), .out_item(out_data)
	);

endmodule

>>> rtl/core/sprb_modred.sv
// ----------------------------------------------------------------------------
// sprb_modred: iterative restoring a mod p
// One quotient bit per cycle, 64-bit dividend, 32-bit modulus.
// ----------------------------------------------------------------------------
module sprb_modred import sprb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] modulus,
	output logic        done,
	output logic [31:0] remainder
);

	logic [63:0] num_q;
	logic [31:0] rem_q;
	logic [31:0] mod_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q, num_q[63]};
	assign diff    = shifted - {1'b0, mod_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
				num_q  <= dividend;
				rem_q  <= '0;
				mod_q  <= modulus;
			end else if (busy_q) begin
				num_q <= {num_q[62:0], 1'b0};
				// partial remainder stays below the modulus, so 32 bits hold it
				rem_q <= diff[32] ? shifted[31:0] : diff[31:0];
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign remainder = rem_q;

endmodule

>>> rtl/core/sprb_front.sv
// ----------------------------------------------------------------------------
// sprb_front: switch test and first-hit reduction
// Reduces (low+diff) mod p, multiplies by the inverse, reduces again.
// ----------------------------------------------------------------------------
module sprb_front import sprb_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	output logic            ready,
	input  in_item_t        req,
	input  logic [23:0]     class_difference,
	input  logic [23:0]     modulus_product,
	input  logic [41:0]     block_span,
	input  logic [6:0]      block_count,
	output logic            job_valid,
	input  logic            job_ready,
	output job_t            job
);

	typedef enum logic [2:0] {IDLE, SUM, MUL, PROD, FIN, SEND} state_t;

	state_t       state_q;
	in_item_t     item_q;
	logic         large_q;
	logic         switch_q;
	logic [31:0]  sum_q;
	logic [63:0]  prod_q;
	logic         mr_start;
	logic [63:0]  mr_num;
	logic         mr_done;
	logic [31:0]  mr_rem;
	logic [CNT_W-1:0] blocks;
	logic [55:0]  lhs;
	logic [48:0]  rhs;
	logic [FLAG_BITS+CNT_W-1:0] line;
	logic         start_eff;

	assign blocks = (block_count > 7'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
	                                                : CNT_W'(block_count);
	assign line   = {blocks, {FLAG_BITS{1'b0}}};
	assign lhs    = item_q.prime * modulus_product;
	assign rhs    = block_span * blocks;
	assign start_eff = item_q.start_req;

	assign ready  = (state_q == IDLE);
	assign mr_start = (state_q == IDLE && valid) || (state_q == MUL);
	assign mr_num = (state_q == MUL) ? prod_q
	                : 64'(req.low_residue) + 64'(class_difference);

	sprb_modred u_mr (
		.clk(clk), .arst_n(arst_n), .start(mr_start), .dividend(mr_num),
		.modulus(state_q == MUL ? item_q.prime : req.prime),
		.done(mr_done), .remainder(mr_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			large_q   <= 1'b0;
			job_valid <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: if (valid) begin
					item_q  <= req;
					state_q <= SUM;
				end
				SUM: if (mr_done) begin
					sum_q   <= mr_rem;
					prod_q  <= '0;
					state_q <= PROD;
					// mode tracking: start clears, then switch test
					switch_q <= (!large_q || start_eff) && (lhs > 56'(rhs));
					if (start_eff) large_q <= (lhs > 56'(rhs));
					else if (lhs > 56'(rhs)) large_q <= 1'b1;
				end
				PROD: begin
					prod_q  <= item_q.inverse * sum_q;
					state_q <= MUL;
				end
				MUL: state_q <= FIN;
				FIN: if (mr_done) begin
					job.start_req  <= start_eff;
					job.switch_now <= switch_q;
					job.prime      <= item_q.prime;
					job.hit        <= mr_rem[23:0];
					job.bucket     <= BLK_W'(mr_rem >> FLAG_BITS);
					job.hit_valid  <= (item_q.prime != 0) &&
					                  (33'(mr_rem) < 33'(line));
					job_valid      <= 1'b1;
					state_q        <= SEND;
				end
				SEND: if (job_ready) begin
					job_valid <= 1'b0;
					state_q   <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/sprb_back.sv
// ----------------------------------------------------------------------------
// sprb_back: bucket counters
// Counters in a registered-read store, read at take, written back in B_UPD;
// valid bits stand for cleared counters; output held in a register.
// ----------------------------------------------------------------------------
module sprb_back import sprb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	output logic      job_ready,
	input  job_t      job,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	typedef enum logic {B_IDLE, B_UPD} state_t;

	state_t                state_q;
	logic [SLOT_BITS-1:0]  fill_mem [FILL_DEPTH];
	logic [SLOT_BITS-1:0]  rd_data;
	logic [MAX_BLOCKS-1:0] nval_q, lval_q;
	logic                  large_q;
	job_t                  job_s1;
	logic                  mode_s1;
	logic                  mode;
	logic                  take;
	logic                  seen;
	logic [SLOT_BITS-1:0]  cur;
	logic                  full;
	logic                  fill_we;

	// one job at a time, and only into an empty result register
	assign job_ready = (state_q == B_IDLE) && !out_valid;
	assign take      = job_valid && job_ready;
	assign mode      = job.start_req ? job.switch_now : (large_q | job.switch_now);

	// clears were applied to the valid bits at take, so they read fresh here
	assign seen    = mode_s1 ? lval_q[job_s1.bucket] : nval_q[job_s1.bucket];
	assign cur     = seen ? rd_data : '0;
	assign full    = (cur == SLOT_MAX);
	assign fill_we = (state_q == B_UPD) && job_s1.hit_valid;

	always_ff @(posedge clk) begin
		if (fill_we)
			fill_mem[{mode_s1, job_s1.bucket}] <= full ? cur : cur + SLOT_BITS'(1);
		if (take)
			rd_data <= fill_mem[{mode, job.bucket}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			nval_q    <= '0;
			lval_q    <= '0;
			large_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (out_ready) out_valid <= 1'b0;
					if (take) begin
						large_q <= mode;
						if (job.start_req) nval_q <= '0;
						if (job.start_req || job.switch_now) lval_q <= '0;
						state_q <= B_UPD;
					end
				end
				B_UPD: begin
					if (job_s1.hit_valid) begin
						if (mode_s1) lval_q[job_s1.bucket] <= 1'b1;
						else         nval_q[job_s1.bucket] <= 1'b1;
					end
					out_valid <= 1'b1;
					state_q   <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_s1  <= job;
			mode_s1 <= mode;
		end
		if (state_q == B_UPD) begin
			out_item.hit_valid     <= job_s1.hit_valid;
			out_item.large_mode    <= mode_s1;
			out_item.bucket_index  <= job_s1.hit_valid ? 6'(job_s1.bucket) : '0;
			out_item.slot_index    <= job_s1.hit_valid ? 16'(cur) : '0;
			out_item.hit_offset    <= job_s1.hit_valid ? job_s1.hit : '0;
			out_item.prime_echo    <= (job_s1.hit_valid && !mode_s1) ? job_s1.prime : '0;
			out_item.slot_overflow <= job_s1.hit_valid && full;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_item)) else $error("result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_UPD |-> !out_valid) else $error("result overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		take && mode |=> large_q) else $error("mode not kept");

endmodule
